/* hw/rtl/ffha_pkg.sv */
package ffha_pkg;

    // Fixed field widths
    localparam int ADDR_W = 20;
    localparam int LEN_W  = 21;
    localparam int CNT_W  = 32;
    localparam int EXT_W  = 7;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // Default configuration
    localparam int DEF_PAGE_BYTES   = 4096;
    localparam int DEF_POOL_PAGES   = 256;
    localparam int DEF_TABLE_DEPTH  = 64;
    localparam int DEF_HEADER_BYTES = 8;
    localparam int DEF_MIN_FRAGMENT = 16;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_POOL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BIG   = 2'd3;

    // Datapath commands
    typedef logic [4:0] cmd_t;
    localparam cmd_t CMD_NONE       = 5'd0;
    localparam cmd_t CMD_LOAD       = 5'd1;
    localparam cmd_t CMD_DECIDE     = 5'd2;
    localparam cmd_t CMD_SCAN_RD    = 5'd3;
    localparam cmd_t CMD_SCAN_NEXT  = 5'd4;
    localparam cmd_t CMD_FOUND      = 5'd5;
    localparam cmd_t CMD_POOL_EMPTY = 5'd6;
    localparam cmd_t CMD_TABLE_FULL = 5'd7;
    localparam cmd_t CMD_PAGE       = 5'd8;
    localparam cmd_t CMD_REM_RD     = 5'd9;
    localparam cmd_t CMD_REM_WR     = 5'd10;
    localparam cmd_t CMD_REM_END    = 5'd11;
    localparam cmd_t CMD_INS_RD     = 5'd12;
    localparam cmd_t CMD_INS_SHIFT  = 5'd13;
    localparam cmd_t CMD_INS_PUT    = 5'd14;
    localparam cmd_t CMD_M_RD0      = 5'd15;
    localparam cmd_t CMD_M_FIRST    = 5'd16;
    localparam cmd_t CMD_M_RD       = 5'd17;
    localparam cmd_t CMD_M_STEP     = 5'd18;
    localparam cmd_t CMD_M_END      = 5'd19;
    localparam cmd_t CMD_PUBLISH    = 5'd20;

    // One free extent
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } extent_t;

    // Datapath flags seen by the controller
    typedef struct packed {
        logic is_alloc;
        logic is_free;
        logic big;
        logic table_full;
        logic scan_end;
        logic pool_empty;
        logic keep_page;
        logic fits;
        logic rem_more;
        logic keep_frag;
        logic idx_zero;
        logic ins_gt;
        logic used_le1;
        logic out_busy;
    } dp_status_t;

endpackage

/* hw/rtl/ffha_datapath.sv */
module ffha_datapath
    import ffha_pkg::*;
#(
    parameter int PAGE_BYTES   = DEF_PAGE_BYTES,
    parameter int POOL_PAGES   = DEF_POOL_PAGES,
    parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES,
    parameter int MIN_FRAGMENT = DEF_MIN_FRAGMENT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output dp_status_t          stat,
    input  logic [KIND_W-1:0]   kind,
    input  logic [ADDR_W-1:0]   size,
    input  logic [ADDR_W-1:0]   address,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ADDR_W-1:0]   user_address,
    output logic [STAT_W-1:0]   status,
    output logic [CNT_W-1:0]    mapped_pages,
    output logic [CNT_W-1:0]    unmapped_pages,
    output logic [CNT_W-1:0]    alloc_count,
    output logic [CNT_W-1:0]    free_count,
    output logic [EXT_W-1:0]    free_extents
);

    localparam int LOG2P = $clog2(PAGE_BYTES);
    localparam int IW    = $clog2(TABLE_DEPTH + 1);
    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int PW    = $clog2(POOL_PAGES + 1);

    // Request registers
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [ADDR_W-1:0] size_reg, size_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0]  total_reg, total_next;

    // Table control and allocator state
    logic [IW-1:0]     used_reg, used_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     wptr_reg, wptr_next;
    logic [PW-1:0]     npage_reg, npage_next;
    logic [CNT_W-1:0]  taken_reg, taken_next;
    logic [CNT_W-1:0]  released_reg, released_next;
    logic [CNT_W-1:0]  allocs_reg, allocs_next;
    logic [CNT_W-1:0]  frees_reg, frees_next;
    extent_t           cur_reg, cur_next;
    logic              keep_reg, keep_next;
    logic [STAT_W-1:0] st_reg, st_next;
    logic [ADDR_W-1:0] user_reg, user_next;

    // Output stage
    logic              ovalid_reg, ovalid_next;
    logic [ADDR_W-1:0] o_user_reg, o_user_next;
    logic [STAT_W-1:0] o_st_reg, o_st_next;
    logic [CNT_W-1:0]  o_taken_reg, o_taken_next;
    logic [CNT_W-1:0]  o_rel_reg, o_rel_next;
    logic [CNT_W-1:0]  o_alloc_reg, o_alloc_next;
    logic [CNT_W-1:0]  o_free_reg, o_free_next;
    logic [EXT_W-1:0]  o_ext_reg, o_ext_next;

    // Extent table
    extent_t           table_mem [TABLE_DEPTH];
    extent_t           rd_q;
    logic [IW-1:0]     rd_idx;
    logic              wr_en;
    logic [IW-1:0]     wr_idx;
    extent_t           wr_data;

    // Arithmetic
    logic              big_alloc, big_free;
    logic [LEN_W:0]    pages_sum, pages_need, pool_left;
    logic [LEN_W-1:0]  rel_sum, rel_pages;
    logic [ADDR_W-1:0] base_addr, chunk;
    logic [LEN_W-1:0]  page_rest, found_rest;
    logic              keep_page;
    logic [LEN_W:0]    end_sum, len_sum;
    logic [LEN_W-1:0]  len_sat;
    logic              adjacent;
    logic [IW:0]       idx_inc;

    assign big_alloc  = total_reg >= LEN_W'(PAGE_BYTES);
    assign big_free   = size_reg >= ADDR_W'(PAGE_BYTES);
    assign pages_sum  = {1'b0, total_reg} + (LEN_W+1)'(PAGE_BYTES - 1);
    assign pages_need = pages_sum >> LOG2P;
    assign pool_left  = (LEN_W+1)'(POOL_PAGES) - (LEN_W+1)'(npage_reg);
    assign rel_sum    = {1'b0, size_reg} + LEN_W'(PAGE_BYTES - 1);
    assign rel_pages  = rel_sum >> LOG2P;
    assign base_addr  = ADDR_W'(CNT_W'(npage_reg) << LOG2P);
    assign chunk      = addr_reg - ADDR_W'(HEADER_BYTES);
    assign page_rest  = LEN_W'(PAGE_BYTES) - total_reg;
    assign keep_page  = page_rest >= LEN_W'(MIN_FRAGMENT);
    assign found_rest = rd_q.len - total_reg;
    assign end_sum    = (LEN_W+1)'(cur_reg.start) + {1'b0, cur_reg.len};
    assign adjacent   = end_sum == (LEN_W+1)'(rd_q.start);
    assign len_sum    = {1'b0, cur_reg.len} + {1'b0, rd_q.len};
    assign len_sat    = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
    assign idx_inc    = {1'b0, idx_reg} + 1'b1;

    // Status to controller
    assign stat.is_alloc   = kind_reg == KIND_ALLOC;
    assign stat.is_free    = kind_reg == KIND_FREE;
    assign stat.big        = (kind_reg == KIND_ALLOC) ? big_alloc : big_free;
    assign stat.table_full = used_reg >= IW'(TABLE_DEPTH);
    assign stat.scan_end   = idx_reg == used_reg;
    assign stat.pool_empty = npage_reg >= PW'(POOL_PAGES);
    assign stat.keep_page  = keep_page;
    assign stat.fits       = rd_q.len >= total_reg;
    assign stat.rem_more   = idx_inc < {1'b0, used_reg};
    assign stat.keep_frag  = keep_reg;
    assign stat.idx_zero   = idx_reg == '0;
    assign stat.ins_gt     = rd_q.start > cur_reg.start;
    assign stat.used_le1   = used_reg <= IW'(1);
    assign stat.out_busy   = ovalid_reg && !out_ready;

    // Table read address
    always_comb
    begin
        unique case (cmd)
            CMD_REM_RD: rd_idx = IW'(idx_inc);
            CMD_INS_RD: rd_idx = idx_reg - 1'b1;
            CMD_M_RD0:  rd_idx = '0;
            default:    rd_idx = idx_reg;
        endcase
    end

    // Next-state logic
    always_comb
    begin
        kind_next     = kind_reg;
        size_next     = size_reg;
        addr_next     = addr_reg;
        total_next    = total_reg;
        used_next     = used_reg;
        idx_next      = idx_reg;
        wptr_next     = wptr_reg;
        npage_next    = npage_reg;
        taken_next    = taken_reg;
        released_next = released_reg;
        allocs_next   = allocs_reg;
        frees_next    = frees_reg;
        cur_next      = cur_reg;
        keep_next     = keep_reg;
        st_next       = st_reg;
        user_next     = user_reg;
        ovalid_next   = ovalid_reg && !out_ready;
        o_user_next   = o_user_reg;
        o_st_next     = o_st_reg;
        o_taken_next  = o_taken_reg;
        o_rel_next    = o_rel_reg;
        o_alloc_next  = o_alloc_reg;
        o_free_next   = o_free_reg;
        o_ext_next    = o_ext_reg;
        wr_en         = 1'b0;
        wr_idx        = idx_reg;
        wr_data       = cur_reg;

        unique case (cmd)
            CMD_LOAD:
            begin
                kind_next  = kind;
                size_next  = size;
                addr_next  = address;
                total_next = {1'b0, size} + LEN_W'(HEADER_BYTES);
                st_next    = ST_OK;
                user_next  = '0;
            end
            CMD_DECIDE:
            begin
                idx_next = '0;
                if (kind_reg == KIND_ALLOC)
                begin
                    allocs_next = allocs_reg + 1'b1;
                    if (big_alloc)
                    begin
                        if (pages_need > (LEN_W+1)'(POOL_PAGES))
                            st_next = ST_BIG;
                        else if (pages_need > pool_left)
                            st_next = ST_POOL;
                        else
                        begin
                            npage_next = npage_reg + PW'(pages_need);
                            taken_next = taken_reg + CNT_W'(pages_need);
                            user_next  = base_addr + ADDR_W'(HEADER_BYTES);
                        end
                    end
                end
                else if (kind_reg == KIND_FREE)
                begin
                    frees_next = frees_reg + 1'b1;
                    if (big_free)
                        released_next = released_reg + CNT_W'(rel_pages);
                    else if (used_reg >= IW'(TABLE_DEPTH))
                        st_next = ST_FULL;
                    else
                    begin
                        cur_next.start = chunk;
                        cur_next.len   = {1'b0, size_reg};
                        idx_next       = used_reg;
                    end
                end
            end
            CMD_SCAN_NEXT:
                idx_next = idx_reg + 1'b1;
            CMD_FOUND:
            begin
                user_next      = rd_q.start + ADDR_W'(HEADER_BYTES);
                cur_next.start = ADDR_W'(rd_q.start + total_reg);
                cur_next.len   = found_rest;
                keep_next      = found_rest >= LEN_W'(MIN_FRAGMENT);
            end
            CMD_POOL_EMPTY:
                st_next = ST_POOL;
            CMD_TABLE_FULL:
                st_next = ST_FULL;
            CMD_PAGE:
            begin
                npage_next     = npage_reg + 1'b1;
                taken_next     = taken_reg + 1'b1;
                user_next      = base_addr + ADDR_W'(HEADER_BYTES);
                cur_next.start = ADDR_W'(base_addr + total_reg);
                cur_next.len   = page_rest;
                idx_next       = used_reg;
            end
            CMD_REM_WR:
            begin
                wr_en    = 1'b1;
                wr_data  = rd_q;
                idx_next = idx_reg + 1'b1;
            end
            CMD_REM_END:
            begin
                used_next = used_reg - 1'b1;
                idx_next  = used_reg - 1'b1;
            end
            CMD_INS_SHIFT:
            begin
                wr_en    = 1'b1;
                wr_data  = rd_q;
                idx_next = idx_reg - 1'b1;
            end
            CMD_INS_PUT:
            begin
                wr_en     = 1'b1;
                used_next = used_reg + 1'b1;
            end
            CMD_M_FIRST:
            begin
                cur_next  = rd_q;
                idx_next  = IW'(1);
                wptr_next = '0;
            end
            CMD_M_STEP:
            begin
                idx_next = IW'(idx_inc);
                if (adjacent)
                    cur_next.len = len_sat;
                else
                begin
                    wr_en     = 1'b1;
                    wr_idx    = wptr_reg;
                    wptr_next = wptr_reg + 1'b1;
                    cur_next  = rd_q;
                end
            end
            CMD_M_END:
            begin
                wr_en     = 1'b1;
                wr_idx    = wptr_reg;
                used_next = wptr_reg + 1'b1;
            end
            CMD_PUBLISH:
            begin
                ovalid_next  = 1'b1;
                o_user_next  = user_reg;
                o_st_next    = st_reg;
                o_taken_next = taken_reg;
                o_rel_next   = released_reg;
                o_alloc_next = allocs_reg;
                o_free_next  = frees_reg;
                o_ext_next   = EXT_W'(used_reg);
            end
            default:
            begin
            end
        endcase
    end

    // Table memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            table_mem[wr_idx[AW-1:0]] <= wr_data;
        rd_q <= table_mem[rd_idx[AW-1:0]];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        size_reg    <= size_next;
        addr_reg    <= addr_next;
        total_reg   <= total_next;
        idx_reg     <= idx_next;
        wptr_reg    <= wptr_next;
        cur_reg     <= cur_next;
        keep_reg    <= keep_next;
        st_reg      <= st_next;
        user_reg    <= user_next;
        o_user_reg  <= o_user_next;
        o_st_reg    <= o_st_next;
        o_taken_reg <= o_taken_next;
        o_rel_reg   <= o_rel_next;
        o_alloc_reg <= o_alloc_next;
        o_free_reg  <= o_free_next;
        o_ext_reg   <= o_ext_next;
    end

    // Allocator state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            npage_reg    <= '0;
            taken_reg    <= '0;
            released_reg <= '0;
            allocs_reg   <= '0;
            frees_reg    <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            used_reg     <= used_next;
            npage_reg    <= npage_next;
            taken_reg    <= taken_next;
            released_reg <= released_next;
            allocs_reg   <= allocs_next;
            frees_reg    <= frees_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    assign out_valid      = ovalid_reg;
    assign user_address   = o_user_reg;
    assign status         = o_st_reg;
    assign mapped_pages   = o_taken_reg;
    assign unmapped_pages = o_rel_reg;
    assign alloc_count    = o_alloc_reg;
    assign free_count     = o_free_reg;
    assign free_extents   = o_ext_reg;

endmodule

/* hw/rtl/ffha_ctrl.sv */
module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t stat,
    output cmd_t       cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECIDE  = 4'd1;
    localparam logic [3:0] S_SCAN    = 4'd2;
    localparam logic [3:0] S_SCAN_CK = 4'd3;
    localparam logic [3:0] S_REM     = 4'd4;
    localparam logic [3:0] S_REM_WR  = 4'd5;
    localparam logic [3:0] S_INS     = 4'd6;
    localparam logic [3:0] S_INS_CK  = 4'd7;
    localparam logic [3:0] S_MERGE   = 4'd8;
    localparam logic [3:0] S_M_FIRST = 4'd9;
    localparam logic [3:0] S_M_LOOP  = 4'd10;
    localparam logic [3:0] S_M_CK    = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [3:0] post_ins;

    assign in_ready = state_reg == S_IDLE;
    assign post_ins = stat.is_free ? S_MERGE : S_DONE;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_DECIDE;
                end
            S_DECIDE:
            begin
                cmd = CMD_DECIDE;
                if (stat.is_alloc && !stat.big)
                    state_next = S_SCAN;
                else if (stat.is_free && !stat.big && !stat.table_full)
                    state_next = S_INS;
                else
                    state_next = S_DONE;
            end
            S_SCAN:
                if (!stat.scan_end)
                begin
                    cmd        = CMD_SCAN_RD;
                    state_next = S_SCAN_CK;
                end
                else if (stat.pool_empty)
                begin
                    cmd        = CMD_POOL_EMPTY;
                    state_next = S_DONE;
                end
                else if (stat.keep_page && stat.table_full)
                begin
                    cmd        = CMD_TABLE_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = CMD_PAGE;
                    state_next = stat.keep_page ? S_INS : S_DONE;
                end
            S_SCAN_CK:
                if (stat.fits)
                begin
                    cmd        = CMD_FOUND;
                    state_next = S_REM;
                end
                else
                begin
                    cmd        = CMD_SCAN_NEXT;
                    state_next = S_SCAN;
                end
            S_REM:
                if (stat.rem_more)
                begin
                    cmd        = CMD_REM_RD;
                    state_next = S_REM_WR;
                end
                else
                begin
                    cmd        = CMD_REM_END;
                    state_next = stat.keep_frag ? S_INS : S_DONE;
                end
            S_REM_WR:
            begin
                cmd        = CMD_REM_WR;
                state_next = S_REM;
            end
            S_INS:
                if (stat.idx_zero)
                begin
                    cmd        = CMD_INS_PUT;
                    state_next = post_ins;
                end
                else
                begin
                    cmd        = CMD_INS_RD;
                    state_next = S_INS_CK;
                end
            S_INS_CK:
                if (stat.ins_gt)
                begin
                    cmd        = CMD_INS_SHIFT;
                    state_next = S_INS;
                end
                else
                begin
                    cmd        = CMD_INS_PUT;
                    state_next = post_ins;
                end
            S_MERGE:
                if (stat.used_le1)
                    state_next = S_DONE;
                else
                begin
                    cmd        = CMD_M_RD0;
                    state_next = S_M_FIRST;
                end
            S_M_FIRST:
            begin
                cmd        = CMD_M_FIRST;
                state_next = S_M_LOOP;
            end
            S_M_LOOP:
                if (stat.scan_end)
                begin
                    cmd        = CMD_M_END;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = CMD_M_RD;
                    state_next = S_M_CK;
                end
            S_M_CK:
            begin
                cmd        = CMD_M_STEP;
                state_next = S_M_LOOP;
            end
            S_DONE:
                if (!stat.out_busy)
                begin
                    cmd        = CMD_PUBLISH;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* hw/rtl/first_fit_heap_allocator_unit.sv */
// Channel  Handshake            Payload
// in       in_valid/in_ready    kind, size, address
// out      out_valid/out_ready  user_address, status, mapped_pages, unmapped_pages,
//                               alloc_count, free_count, free_extents
//
// One request at a time. Stats reads and large requests pass only through load, decide
// and publish; a small request spends a read and a follow-up step on each table entry
// touched by the first-fit scan, the removal shift, the ordered insert and the merge
// pass, since the extent table is a single memory with a registered read.
// Reset clears counters, table fill and output valid; table contents need none.
// A new request is taken while the previous result waits in the output register.
module first_fit_heap_allocator_unit
    import ffha_pkg::*;
#(
    parameter int PAGE_BYTES   = DEF_PAGE_BYTES,
    parameter int POOL_PAGES   = DEF_POOL_PAGES,
    parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES,
    parameter int MIN_FRAGMENT = DEF_MIN_FRAGMENT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KIND_W-1:0] kind,
    input  logic [ADDR_W-1:0] size,
    input  logic [ADDR_W-1:0] address,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ADDR_W-1:0] user_address,
    output logic [STAT_W-1:0] status,
    output logic [CNT_W-1:0]  mapped_pages,
    output logic [CNT_W-1:0]  unmapped_pages,
    output logic [CNT_W-1:0]  alloc_count,
    output logic [CNT_W-1:0]  free_count,
    output logic [EXT_W-1:0]  free_extents
);

    cmd_t       cmd;
    dp_status_t stat;

    ffha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffha_datapath #(
        .PAGE_BYTES   (PAGE_BYTES),
        .POOL_PAGES   (POOL_PAGES),
        .TABLE_DEPTH  (TABLE_DEPTH),
        .HEADER_BYTES (HEADER_BYTES),
        .MIN_FRAGMENT (MIN_FRAGMENT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .kind           (kind),
        .size           (size),
        .address        (address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .user_address   (user_address),
        .status         (status),
        .mapped_pages   (mapped_pages),
        .unmapped_pages (unmapped_pages),
        .alloc_count    (alloc_count),
        .free_count     (free_count),
        .free_extents   (free_extents)
    );

endmodule

/* tb/sv/tb_first_fit_heap_allocator_unit.sv */
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator_unit;
    import ffha_pkg::*;

    localparam int PAGE   = DEF_PAGE_BYTES;
    localparam int POOL   = DEF_POOL_PAGES;
    localparam int DEPTH  = DEF_TABLE_DEPTH;
    localparam int HDR    = DEF_HEADER_BYTES;
    localparam int MINFR  = DEF_MIN_FRAGMENT;
    localparam logic [KIND_W-1:0] KIND_STATS = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int N_RANDOM   = 1335;
    localparam int DRAIN_WAIT = 8 * DEPTH + 100;
    localparam longint CYCLE_LIMIT = 64'd8000000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] address;
    } request_t;

    typedef struct packed {
        logic [ADDR_W-1:0] user_address;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  mapped_pages;
        logic [CNT_W-1:0]  unmapped_pages;
        logic [CNT_W-1:0]  alloc_count;
        logic [CNT_W-1:0]  free_count;
        logic [EXT_W-1:0]  free_extents;
    } heap_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [KIND_W-1:0] kind = '0;
    logic [ADDR_W-1:0] size = '0;
    logic [ADDR_W-1:0] address = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [ADDR_W-1:0] user_address;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  mapped_pages, unmapped_pages, alloc_count, free_count;
    logic [EXT_W-1:0]  free_extents;

    first_fit_heap_allocator_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .size(size), .address(address),
        .out_valid(out_valid), .out_ready(out_ready),
        .user_address(user_address), .status(status),
        .mapped_pages(mapped_pages), .unmapped_pages(unmapped_pages),
        .alloc_count(alloc_count), .free_count(free_count),
        .free_extents(free_extents)
    );

    always #4 clk = ~clk;

    // Shadow copy of the heap state
    logic [ADDR_W-1:0] ext_start [DEPTH];
    logic [LEN_W-1:0]  ext_len [DEPTH];
    int          ext_used = 0;
    int unsigned next_pg = 0;
    logic [CNT_W-1:0] pg_taken = '0, pg_released = '0, n_allocs = '0, n_frees = '0;

    request_t     pending [$];
    heap_result_t expected_results [$];
    // Chunks handed out and not yet freed: user address and recorded size
    logic [ADDR_W-1:0] live_addr [$];
    logic [ADDR_W-1:0] live_size [$];

    int     errors = 0;
    int     n_accepted = 0;
    int     send_idle = 17;
    int     recv_idle = 78;
    logic   in_xfer = 1'b0;
    logic   held_off = 1'b0;
    int     hold_cnt = 0;
    longint cycles = 0;

    function automatic void extent_remove(int idx);
        for (int i = idx; i + 1 < ext_used; i++) begin
            ext_start[i] = ext_start[i + 1];
            ext_len[i]   = ext_len[i + 1];
        end
        ext_used--;
    endfunction

    function automatic void extent_insert(logic [ADDR_W-1:0] s, longint len);
        int pos;
        pos = 0;
        if (ext_used >= DEPTH) return;
        while (pos < ext_used && ext_start[pos] <= s) pos++;
        for (int i = ext_used; i > pos; i--) begin
            ext_start[i] = ext_start[i - 1];
            ext_len[i]   = ext_len[i - 1];
        end
        ext_start[pos] = s;
        ext_len[pos]   = (len > longint'(LEN_MAX)) ? LEN_MAX : LEN_W'(len);
        ext_used++;
    endfunction

    // Coalesce every adjacent pair
    function automatic void extent_coalesce();
        int i;
        longint ext_end, sum;
        i = 0;
        while (i + 1 < ext_used) begin
            ext_end = longint'(ext_start[i]) + longint'(ext_len[i]);
            if (ext_end == longint'(ext_start[i + 1])) begin
                sum = longint'(ext_len[i]) + longint'(ext_len[i + 1]);
                ext_len[i] = (sum > longint'(LEN_MAX)) ? LEN_MAX : LEN_W'(sum);
                extent_remove(i + 1);
            end else begin
                i++;
            end
        end
    endfunction

    function automatic heap_result_t heap_step(request_t rq);
        heap_result_t r;
        longint total, pages, rest, base;
        logic   found;
        logic [ADDR_W-1:0] s;
        r = '0;
        r.status = ST_OK;
        if (rq.kind == KIND_ALLOC) begin
            total = longint'(rq.size) + HDR;
            n_allocs++;
            if (total >= PAGE) begin
                pages = (total + PAGE - 1) / PAGE;
                if (pages > POOL) r.status = ST_BIG;
                else if (pages > POOL - next_pg) r.status = ST_POOL;
                else begin
                    base = longint'(next_pg) * PAGE;
                    next_pg += int'(pages);
                    pg_taken += CNT_W'(pages);
                    r.user_address = ADDR_W'(base + HDR);
                end
            end else begin
                found = 1'b0;
                for (int i = 0; i < ext_used && !found; i++) begin
                    if (longint'(ext_len[i]) >= total) begin
                        found = 1'b1;
                        s = ext_start[i];
                        rest = longint'(ext_len[i]) - total;
                        extent_remove(i);
                        if (rest >= MINFR) extent_insert(ADDR_W'(s + total), rest);
                        r.user_address = ADDR_W'(s + HDR);
                    end
                end
                if (!found) begin
                    rest = PAGE - total;
                    if (next_pg >= POOL) r.status = ST_POOL;
                    else if (rest >= MINFR && ext_used >= DEPTH) r.status = ST_FULL;
                    else begin
                        base = longint'(next_pg) * PAGE;
                        next_pg++;
                        pg_taken++;
                        if (rest >= MINFR) extent_insert(ADDR_W'(base + total), rest);
                        r.user_address = ADDR_W'(base + HDR);
                    end
                end
            end
        end else if (rq.kind == KIND_FREE) begin
            n_frees++;
            if (rq.size >= PAGE) begin
                pg_released += CNT_W'((longint'(rq.size) + PAGE - 1) / PAGE);
            end else if (ext_used >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                extent_insert(rq.address - ADDR_W'(HDR), longint'(rq.size));
                extent_coalesce();
            end
        end
        r.mapped_pages   = pg_taken;
        r.unmapped_pages = pg_released;
        r.alloc_count    = n_allocs;
        r.free_count     = n_frees;
        r.free_extents   = EXT_W'(ext_used);
        return r;
    endfunction

    task automatic push_req(logic [KIND_W-1:0] k, logic [ADDR_W-1:0] sz,
                            logic [ADDR_W-1:0] ad);
        request_t rq;
        rq.kind = k;
        rq.size = sz;
        rq.address = ad;
        pending.push_back(rq);
    endtask

    // Free a live chunk; falls back to a stray free if none is held
    task automatic push_live_free();
        int j;
        if (live_addr.size() == 0) begin
            push_req(KIND_FREE, 20'($urandom_range(16, 4095)), 20'($urandom));
            return;
        end
        j = $urandom_range(live_addr.size() - 1);
        push_req(KIND_FREE, live_size[j], live_addr[j]);
        live_addr.delete(j);
        live_size.delete(j);
    endtask

    task automatic push_random();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            push_req(KIND_ALLOC, 20'($urandom_range(0, 200)), 20'($urandom));
        else if (pick < 47)
            push_req(KIND_ALLOC, 20'($urandom_range(201, 4087)), 20'($urandom));
        else if (pick < 50)
            push_req(KIND_ALLOC, 20'($urandom_range(4088, 2 * PAGE)), 20'($urandom));
        else if (pick < 84)
            push_live_free();
        else if (pick < 92)
            push_req(KIND_FREE, 20'($urandom), 20'($urandom));
        else
            push_req(2'($urandom_range(2, 3)), 20'($urandom), 20'($urandom));
    endtask

    // Stimulus
    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Directed: kinds, extremes, large path, dropped remainder
        push_req(KIND_STATS, 20'hFFFFF, 20'hFFFFF);
        push_req(KIND_SPARE, 20'h00000, 20'h00000);
        push_req(KIND_ALLOC, 20'd0, 20'd0);
        push_req(KIND_ALLOC, 20'hFFFFF, 20'hFFFFF);
        push_req(KIND_ALLOC, 20'(PAGE - HDR), 20'd0);
        push_req(KIND_ALLOC, 20'(PAGE - HDR - MINFR + 1), 20'd0);
        push_req(KIND_ALLOC, 20'd100, 20'd0);
        push_req(KIND_ALLOC, 20'd100, 20'd0);
        push_req(KIND_FREE, 20'(PAGE), 20'h12345);
        push_req(KIND_FREE, 20'hFFFFF, 20'hFFFFF);
        push_req(KIND_FREE, 20'd16, 20'd0);
        // equal starts
        push_req(KIND_FREE, 20'd24, 20'hE0008);
        push_req(KIND_FREE, 20'd40, 20'hE0008);
        // adjacent chunks that coalesce
        push_req(KIND_FREE, 20'd32, 20'hD0008);
        push_req(KIND_FREE, 20'd32, 20'hD0028);
        // fill the table, then overflow it
        for (int k = 0; k < DEPTH; k++)
            push_req(KIND_FREE, 20'd16, 20'hF0008 + 20'(k * 64));
        push_req(KIND_FREE, 20'd16, 20'h70008);
        push_req(KIND_ALLOC, 20'd300, 20'd0);
        push_req(KIND_ALLOC, 20'(PAGE - HDR - 4), 20'd0);
        for (int k = 0; k < 20; k++)
            push_req(KIND_ALLOC, 20'd8, 20'd0);

        // Random part, fed a few at a time so frees can target live chunks
        for (int n = 0; n < N_RANDOM; n++) begin
            while (pending.size() > 2) @(posedge clk);
            push_random();
        end

        // Exhaust the pool
        push_req(KIND_ALLOC, 20'd1000000, 20'd0);
        push_req(KIND_ALLOC, 20'd1000000, 20'd0);
        push_req(KIND_ALLOC, 20'(PAGE), 20'd0);
        for (int k = 0; k < 10; k++)
            push_req(KIND_ALLOC, 20'($urandom_range(1000, 4000)), 20'd0);

        while (pending.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("tb_first_fit_heap_allocator_unit OK");
        else
            $display("tb_first_fit_heap_allocator_unit NOT OK");
        $finish;
    end

    // Idle mix follows progress through the run
    always @(posedge clk) begin
        if (n_accepted < 480) begin
            send_idle <= 17;
            recv_idle <= 78;
        end else if (n_accepted < 960) begin
            send_idle <= 78;
            recv_idle <= 17;
        end else begin
            send_idle <= 0;
            recv_idle <= 0;
        end
    end

    // Request driver
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_xfer)) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_idle) begin
                kind     <= pending[0].kind;
                size     <= pending[0].size;
                address  <= pending[0].address;
                in_valid <= 1'b1;
                void'(pending.pop_front());
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver, with one long hold-off to back the block up
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            out_ready <= 1'b0;
            hold_cnt  <= hold_cnt - 1;
        end else if (!held_off && n_accepted >= 200) begin
            out_ready <= 1'b0;
            held_off  <= 1'b1;
            hold_cnt  <= 3000;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Monitor: predict on request transfer, check on result transfer
    always @(posedge clk) begin
        request_t     rq;
        heap_result_t exp_r, got;
        in_xfer <= in_valid && in_ready;
        if (in_valid && in_ready) begin
            rq.kind = kind;
            rq.size = size;
            rq.address = address;
            exp_r = heap_step(rq);
            expected_results.push_back(exp_r);
            n_accepted <= n_accepted + 1;
            if (rq.kind == KIND_ALLOC && exp_r.status == ST_OK) begin
                live_addr.push_back(exp_r.user_address);
                live_size.push_back(rq.size + ADDR_W'(HDR));
            end
        end
        if (out_valid && out_ready) begin
            got.user_address   = user_address;
            got.status         = status;
            got.mapped_pages   = mapped_pages;
            got.unmapped_pages = unmapped_pages;
            got.alloc_count    = alloc_count;
            got.free_count     = free_count;
            got.free_extents   = free_extents;
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got.user_address !== exp_r.user_address) begin
                    $error("user_address: expected %0h, got %0h",
                           exp_r.user_address, got.user_address);
                    errors++;
                end
                if (got.status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, got.status);
                    errors++;
                end
                if (got.mapped_pages !== exp_r.mapped_pages) begin
                    $error("mapped_pages: expected %0d, got %0d",
                           exp_r.mapped_pages, got.mapped_pages);
                    errors++;
                end
                if (got.unmapped_pages !== exp_r.unmapped_pages) begin
                    $error("unmapped_pages: expected %0d, got %0d",
                           exp_r.unmapped_pages, got.unmapped_pages);
                    errors++;
                end
                if (got.alloc_count !== exp_r.alloc_count) begin
                    $error("alloc_count: expected %0d, got %0d",
                           exp_r.alloc_count, got.alloc_count);
                    errors++;
                end
                if (got.free_count !== exp_r.free_count) begin
                    $error("free_count: expected %0d, got %0d",
                           exp_r.free_count, got.free_count);
                    errors++;
                end
                if (got.free_extents !== exp_r.free_extents) begin
                    $error("free_extents: expected %0d, got %0d",
                           exp_r.free_extents, got.free_extents);
                    errors++;
                end
            end
        end
    end

    // Timeout
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_first_fit_heap_allocator_unit NOT OK");
            $finish;
        end
    end

endmodule

/* sim.f */
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_datapath.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/first_fit_heap_allocator_unit.sv
tb/sv/tb_first_fit_heap_allocator_unit.sv
